// ===== hdl/dmph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-matrix print head controller package
// Shared types, constants and register codes for the print head controller.
// ----------------------------------------------------------------------------
package dmph_pkg;

  // Head position width and the width used for saturating head moves.
  localparam int PosBits  = 23;
  localparam int ProdBits = 22;
  localparam int SumBits  = ((PosBits > ProdBits) ? PosBits : ProdBits) + 2;
  localparam int DotXBits = 23;

  localparam logic signed [SumBits-1:0] PosMaxExt =
    {{(SumBits-PosBits+1){1'b0}}, {(PosBits-1){1'b1}}};
  localparam logic signed [SumBits-1:0] PosMinExt =
    {{(SumBits-PosBits+1){1'b1}}, {(PosBits-1){1'b0}}};

  // Command queue between front and back.
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  // Command bytes and fixed values.
  localparam logic [7:0] CmdFeed      = 8'hA4;
  localparam logic [7:0] CmdStartBase = 8'hA8;
  localparam logic [7:0] CmdLfMode    = 8'hAC;
  localparam logic [7:0] CmdReset     = 8'hB8;
  localparam logic [7:0] CmdStop      = 8'hC0;
  localparam logic [7:0] CmdLfFeed    = 8'h80;
  localparam logic [7:0] IdByte       = 8'hF8;
  localparam logic [8:0] FullFeed     = 9'd256;
  localparam logic [15:0] TopLine     = 16'd360;
  localparam logic [15:0] YMax        = 16'hFFFF;
  localparam int StartTrim            = 11;
  localparam int StopTrim             = 9;
  localparam int ColBase              = 5;

  // Configuration register indexes.
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 13;
  localparam logic [CfgIdxBits-1:0] CfgEnable   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgBail     = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgFastStep = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgSlowStep = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPitch    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgLimit    = 3'd5;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_PRINTING = 2'd1,
    MODE_LINEFEED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_DOT  = 2'd1,
    KIND_PAGE = 2'd2
  } kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_PINS = 1'b1
  } back_state_e;

  // One queued entry: a port read or a complete two-byte command.
  typedef struct packed {
    logic       is_read;
    logic       cmd_port;
    logic [7:0] c0;
    logic [7:0] c1;
  } cmd_t;

  typedef struct packed {
    logic        enabled;
    logic        bail_in;
    logic [3:0]  fast_step;
    logic [3:0]  slow_step;
    logic [4:0]  pitch;
    logic [12:0] limit;
  } cfg_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           id_byte;
    logic                 no_printer;
    logic                 bail_flag;
    logic                 head_away;
    logic [DotXBits-1:0]  dot_x;
    logic [15:0]          dot_y;
    logic                 last;
  } res_t;

endpackage

// ===== hdl/dmph_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print head front end
// Accepts port beats, pairs writes into two-byte commands and queues
// reads and complete commands for the back end.
// ----------------------------------------------------------------------------
module dmph_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [1:0]    s_user_i,   // [0] operation, [1] port_sel
  input  logic [7:0]    s_data_i,   // [7:0] data_in
  input  logic          q_full_i,
  output logic          push_o,
  output dmph_pkg::cmd_t push_cmd_o
);

  logic       have_first_q, have_first_d;
  logic [7:0] first_q, first_d;
  logic       accept;
  logic       is_read;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign is_read   = s_user_i[0];

  // Byte pairing: reads pass straight through and leave the pairing alone.
  always_comb begin
    have_first_d = have_first_q;
    first_d      = first_q;
    push_o       = 1'b0;
    push_cmd_o.is_read  = is_read;
    push_cmd_o.cmd_port = !s_user_i[1];
    push_cmd_o.c0       = first_q;
    push_cmd_o.c1       = s_data_i;
    if (accept) begin
      if (is_read) begin
        push_o = 1'b1;
      end else if (!have_first_q) begin
        have_first_d = 1'b1;
        first_d      = s_data_i;
      end else begin
        have_first_d = 1'b0;
        push_o       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      first_q      <= 8'd0;
    end else begin
      have_first_q <= have_first_d;
      first_q      <= first_d;
    end
  end

endmodule

// ===== hdl/dmph_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print head command queue
// Short first-in first-out queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module dmph_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dmph_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dmph_pkg::cmd_t head_o
);

  dmph_pkg::cmd_t                        mem_q [dmph_pkg::FifoDepth];
  logic [dmph_pkg::FifoPtrBits-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [dmph_pkg::FifoCntBits-1:0]      cnt_q, cnt_d;
  logic                                  do_push, do_pop;

  assign full_o  = (cnt_q == dmph_pkg::FifoCntBits'(dmph_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/dmph_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print head back end
// Executes queued reads and commands, keeps head and paper state, steps pins
// one per cycle, stalling while a dot waits, and holds the result register.
// ----------------------------------------------------------------------------
module dmph_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dmph_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  dmph_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output dmph_pkg::res_t m_res_o
);

  dmph_pkg::back_state_e state_q, state_d;
  dmph_pkg::mode_e       mode_q, mode_d;
  logic                  left_q, left_d;
  logic                  slow_q, slow_d;
  logic                  started_q, started_d;
  logic signed [dmph_pkg::PosBits-1:0] head_q, head_d, head_mv;
  logic [15:0]           vpos_q, vpos_d;
  logic [8:0]            pins_q, pins_d;
  logic [7:0]            yoff_q, yoff_d;
  logic [3:0]            col_q, col_d;
  logic                  out_valid_q, out_valid_d;
  dmph_pkg::res_t        out_q, out_d;

  logic                  can_load, emit, pins_go, pins_done;
  logic                  mv_en, mv_left, mv_slow;
  logic signed [16:0]    mv_mag;
  logic [3:0]            mv_step;
  logic signed [dmph_pkg::ProdBits-1:0] prod;
  logic signed [dmph_pkg::SumBits-1:0]  delta, sum;
  logic [8:0]            feed_n;
  logic [16:0]           fed_sum, ysum;
  logic [15:0]           fed;
  logic                  eject;
  logic [14:0]           h_print;
  logic [8:0]            h_start;
  logic                  head_pos_gt0;
  logic [7:0]            c0, c1;

  assign c0        = q_cmd_i.c0;
  assign c1        = q_cmd_i.c1;
  assign can_load  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

  assign head_pos_gt0 = !head_q[dmph_pkg::PosBits-1] && (head_q != '0);

  // Shared head move unit: step times distance, signed by direction, saturated.
  always_comb begin
    mv_step = mv_slow ? cfg_i.slow_step : cfg_i.fast_step;
    prod    = mv_mag * $signed({1'b0, mv_step});
    delta   = mv_left ? -dmph_pkg::SumBits'(prod) : dmph_pkg::SumBits'(prod);
    sum     = dmph_pkg::SumBits'(head_q) + delta;
    if (sum > dmph_pkg::PosMaxExt) begin
      head_mv = dmph_pkg::PosMaxExt[dmph_pkg::PosBits-1:0];
    end else if (sum < dmph_pkg::PosMinExt) begin
      head_mv = dmph_pkg::PosMinExt[dmph_pkg::PosBits-1:0];
    end else begin
      head_mv = sum[dmph_pkg::PosBits-1:0];
    end
  end

  // Paper feed with saturation and the page-end test.
  always_comb begin
    feed_n  = (mode_q == dmph_pkg::MODE_LINEFEED) ? dmph_pkg::FullFeed : {1'b0, c1};
    fed_sum = {1'b0, vpos_q} + 17'(feed_n);
    fed     = fed_sum[16] ? dmph_pkg::YMax : fed_sum[15:0];
    eject   = (fed >= {3'b000, cfg_i.limit}) && started_q;
    ysum    = {1'b0, vpos_q} + 17'(yoff_q);
    h_print = {1'b0, c0[5:0], 8'd0} + ((c1 == 8'd0) ? 15'd256 : {7'd0, c1});
    h_start = (c1 == 8'd0) ? 9'd256 : {1'b0, c1};
  end

  // Command execution and result generation.
  always_comb begin
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    pins_go   = 1'b0;
    pins_done = 1'b0;
    mode_d    = mode_q;
    left_d    = left_q;
    slow_d    = slow_q;
    started_d = started_q;
    vpos_d    = vpos_q;
    pins_d    = pins_q;
    yoff_d    = yoff_q;
    col_d     = col_q;
    mv_en     = 1'b0;
    mv_mag    = '0;
    mv_left   = left_q;
    mv_slow   = slow_q;
    out_d            = out_q;
    out_d.kind       = dmph_pkg::KIND_READ;
    out_d.id_byte    = 8'd0;
    out_d.no_printer = 1'b0;
    out_d.bail_flag  = 1'b0;
    out_d.head_away  = 1'b0;
    out_d.dot_x      = '0;
    out_d.dot_y      = 16'd0;
    out_d.last       = 1'b1;

    case (state_q)
      dmph_pkg::BK_IDLE: begin
        if (q_valid_i && can_load) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_read) begin
            // Status or id read.
            emit = 1'b1;
            if (!cfg_i.enabled) begin
              out_d.no_printer = 1'b1;
            end else if (q_cmd_i.cmd_port) begin
              out_d.id_byte = dmph_pkg::IdByte;
            end else begin
              out_d.bail_flag = cfg_i.bail_in;
              out_d.head_away = head_pos_gt0;
            end
          end else begin
            case (mode_q)
              dmph_pkg::MODE_LINEFEED: begin
                if (c0 == dmph_pkg::CmdStop) begin
                  mode_d = dmph_pkg::MODE_NORMAL;
                end else if (c0 == dmph_pkg::CmdLfFeed) begin
                  vpos_d = fed;
                  if (eject) begin
                    vpos_d     = dmph_pkg::TopLine;
                    started_d  = 1'b0;
                    emit       = 1'b1;
                    out_d.kind = dmph_pkg::KIND_PAGE;
                  end
                end
              end
              dmph_pkg::MODE_PRINTING: begin
                if (c0[7:6] == 2'b10) begin
                  // Head move within the pass.
                  mv_en  = 1'b1;
                  mv_mag = $signed({2'b00, h_print});
                end else if (c0[7:6] == 2'b00) begin
                  // Pin column: fire pins over the next cycles, or just move.
                  col_d = 4'({1'b0, c0[3:1]} + 4'(dmph_pkg::ColBase));
                  if ({c0[0], c1} == 9'd0) begin
                    mv_en  = 1'b1;
                    mv_mag = $signed(17'({1'b0, c0[3:1]} + 4'(dmph_pkg::ColBase)));
                  end else begin
                    pins_d  = {c0[0], c1};
                    yoff_d  = 8'd0;
                    pins_go = 1'b1;
                  end
                end else if (c0 == dmph_pkg::CmdStop && c1 == 8'd0) begin
                  mode_d = dmph_pkg::MODE_NORMAL;
                  mv_en  = 1'b1;
                  mv_mag = 17'(dmph_pkg::StopTrim);
                end
              end
              default: begin
                if (c0 == dmph_pkg::CmdFeed) begin
                  vpos_d = fed;
                end else if (c0[7:2] == dmph_pkg::CmdStartBase[7:2]) begin
                  // Start of a print pass sets direction and speed first.
                  mode_d  = dmph_pkg::MODE_PRINTING;
                  left_d  = !c0[0];
                  slow_d  = c0[1];
                  mv_left = !c0[0];
                  mv_slow = c0[1];
                  mv_en   = 1'b1;
                  mv_mag  = $signed({8'd0, h_start}) - 17'(dmph_pkg::StartTrim);
                end else if (c0 == dmph_pkg::CmdLfMode) begin
                  mode_d = dmph_pkg::MODE_LINEFEED;
                  vpos_d = fed;
                  if (eject) begin
                    vpos_d     = dmph_pkg::TopLine;
                    started_d  = 1'b0;
                    emit       = 1'b1;
                    out_d.kind = dmph_pkg::KIND_PAGE;
                  end
                end else if (c0 == dmph_pkg::CmdReset && q_cmd_i.cmd_port && c1 == 8'd0) begin
                  mode_d = dmph_pkg::MODE_NORMAL;
                  left_d = 1'b0;
                  slow_d = 1'b0;
                end
              end
            endcase
          end
        end
      end
      dmph_pkg::BK_PINS: begin
        // One pin per cycle; a fired pin waits for room in the result register.
        if (!pins_q[0] || can_load) begin
          if (pins_q[0]) begin
            emit        = 1'b1;
            started_d   = 1'b1;
            out_d.kind  = dmph_pkg::KIND_DOT;
            out_d.dot_x = dmph_pkg::DotXBits'(head_q);
            out_d.dot_y = ysum[16] ? dmph_pkg::YMax : ysum[15:0];
            out_d.last  = (pins_q[8:1] == 8'd0);
          end
          pins_d = {1'b0, pins_q[8:1]};
          yoff_d = 8'(yoff_q + {3'b000, cfg_i.pitch});
          if (pins_q[8:1] == 8'd0) begin
            pins_done = 1'b1;
            mv_en     = 1'b1;
            mv_mag    = $signed({13'd0, col_q});
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Head update, with the reset command clearing the position.
  always_comb begin
    head_d = head_q;
    if (mv_en) begin
      head_d = head_mv;
    end else if (q_pop_o && !q_cmd_i.is_read && mode_q == dmph_pkg::MODE_NORMAL &&
                 c0 == dmph_pkg::CmdReset && q_cmd_i.cmd_port && c1 == 8'd0) begin
      head_d = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmph_pkg::BK_IDLE: begin
        if (pins_go) begin
          state_d = dmph_pkg::BK_PINS;
        end
      end
      dmph_pkg::BK_PINS: begin
        if (pins_done) begin
          state_d = dmph_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dmph_pkg::BK_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmph_pkg::BK_IDLE;
      mode_q      <= dmph_pkg::MODE_NORMAL;
      left_q      <= 1'b0;
      slow_q      <= 1'b0;
      started_q   <= 1'b0;
      head_q      <= '0;
      vpos_q      <= dmph_pkg::TopLine;
      pins_q      <= 9'd0;
      yoff_q      <= 8'd0;
      col_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      left_q      <= left_d;
      slow_q      <= slow_d;
      started_q   <= started_d;
      head_q      <= head_d;
      vpos_q      <= vpos_d;
      pins_q      <= pins_d;
      yoff_q      <= yoff_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hdl/dot_matrix_print_head_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-matrix print head controller
// Nine-pin print head controller behind a command port and a data port.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries CPU port accesses: tuser[0] is the operation
//   (0 write, 1 read), tuser[1] the port (0 command, 1 data), tdata the byte.
//   Writes pair into two-byte commands. The master stream returns read
//   responses, dot results and page-eject results; tlast marks the last
//   result caused by one input beat. The config channel writes registers
//   0..5 (enable, bail bar, fast step, slow step, pin pitch, page limit);
//   the user must write them only while the block is idle, which the block
//   itself does not enforce; the channel is always ready. A beat's first
//   result passes the queue and the result register. Throughput: one beat
//   per cycle for reads and commands without pins while the receiver keeps
//   up; a pin command spends one back-end cycle per pin up to its highest
//   fired pin (at most nine), set by the single pin sequencer. A four-entry
//   queue decouples input acceptance from execution. Reset clears the
//   pairing, head, mode and page flag, puts the paper at line 360 and loads
//   the register defaults. When the receiver stalls the result register
//   holds, execution pauses and the queue fills before the input side stops.
// ----------------------------------------------------------------------------
module dot_matrix_print_head_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] port_sel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] id_byte, [8] no_printer, [9] bail_flag, [10] head_away,
  // [33:11] dot_x, [49:34] dot_y, [55:50] zero
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [dmph_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [dmph_pkg::CfgDataBits-1:0] cfg_data_i
);

  dmph_pkg::cfg_t cfg_q, cfg_d;
  dmph_pkg::cmd_t push_cmd, head_cmd;
  dmph_pkg::res_t res;
  logic           push, q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dmph_pkg::CfgEnable:   cfg_d.enabled   = cfg_data_i[0];
        dmph_pkg::CfgBail:     cfg_d.bail_in   = cfg_data_i[0];
        dmph_pkg::CfgFastStep: cfg_d.fast_step = cfg_data_i[3:0];
        dmph_pkg::CfgSlowStep: cfg_d.slow_step = cfg_data_i[3:0];
        dmph_pkg::CfgPitch:    cfg_d.pitch     = cfg_data_i[4:0];
        dmph_pkg::CfgLimit:    cfg_d.limit     = cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled   <= 1'b1;
      cfg_q.bail_in   <= 1'b1;
      cfg_q.fast_step <= 4'd2;
      cfg_q.slow_step <= 4'd1;
      cfg_q.pitch     <= 5'd5;
      cfg_q.limit     <= 13'd4208;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dmph_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_user_i   (s_axis_tuser),
    .s_data_i   (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  dmph_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  dmph_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  // Result beat packing.
  assign m_axis_tdata = {6'd0, res.dot_y, res.dot_x, res.head_away, res.bail_flag,
                         res.no_printer, res.id_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== verif/dot_matrix_print_head_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-matrix print head controller testbench
// Drives port reads and two-byte commands into the controller and predicts
// every read response, fired dot and page eject. The checks run through
// several register settings: defaults, both ends of every range, zero steps
// and a random set. The first part is directed: paper fed to its limit,
// nine-pin columns, head moves, stop, reset and an unknown command. It is
// followed by a head sweep into both saturation limits and random print
// passes, paper feeds and noise, with random idling on both streams.
// ----------------------------------------------------------------------------
module dot_matrix_print_head_controller_test;
  import dmph_pkg::*;

  localparam bit         OpWrite     = 1'b0;
  localparam bit         OpRead      = 1'b1;
  localparam bit         PortCmd     = 1'b0;
  localparam bit         PortData    = 1'b1;
  localparam logic [7:0] HeadMoveLo  = 8'h80;
  localparam int         IdlePct     = 28;
  localparam int         IdleTail    = 64;
  localparam int         HoldCycles  = 400;
  localparam int         MaxReports  = 40;
  localparam longint     TimeLimitNs = 64'd10_000_000;

  // Predicts the controller's results from the beats it accepts.
  class print_head_scoreboard;
    bit          enabled;
    bit          bail_in;
    bit [3:0]    fast_step;
    bit [3:0]    slow_step;
    bit [4:0]    pitch;
    bit [12:0]   limit;
    bit          have_first;
    bit [7:0]    first_byte;
    mode_e       mode;
    bit          dir_left;
    bit          slow;
    longint      head;
    int unsigned vpos;
    bit          page_started;
    res_t        awaited_q[$];
    int          errors, beats, reads, dots, pages;

    function new();
      enabled = 1'b1;
      bail_in = 1'b1;
      fast_step = 4'd2;
      slow_step = 4'd1;
      pitch = 5'd5;
      limit = 13'd4208;
      have_first = 1'b0;
      first_byte = '0;
      mode = MODE_NORMAL;
      dir_left = 1'b0;
      slow = 1'b0;
      head = 0;
      vpos = TopLine;
      page_started = 1'b0;
      errors = 0;
      beats = 0;
      reads = 0;
      dots = 0;
      pages = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        CfgEnable:   enabled = val[0];
        CfgBail:     bail_in = val[0];
        CfgFastStep: fast_step = val[3:0];
        CfgSlowStep: slow_step = val[3:0];
        CfgPitch:    pitch = val[4:0];
        CfgLimit:    limit = val[12:0];
        default: ;
      endcase
    endfunction

    function void add(kind_e k, logic [7:0] id, bit nop, bit bail, bit away,
                      longint x, int unsigned y, bit tl);
      res_t r;
      r.kind = k;
      r.id_byte = id;
      r.no_printer = nop;
      r.bail_flag = bail;
      r.head_away = away;
      r.dot_x = x[DotXBits-1:0];
      r.dot_y = y[15:0];
      r.last = tl;
      awaited_q.push_back(r);
    endfunction

    function longint step_now();
      return slow ? slow_step : fast_step;
    endfunction

    // Head moves saturate at the signed range of the position register.
    function void move_head(longint halfdots);
      longint lo, hi, v;
      lo = -(longint'(1) << (PosBits - 1));
      hi = (longint'(1) << (PosBits - 1)) - 1;
      v = dir_left ? head - halfdots : head + halfdots;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      head = v;
    endfunction

    function void feed(int unsigned n);
      vpos = (vpos + n > YMax) ? YMax : vpos + n;
    endfunction

    function void check_page_end();
      if (vpos >= limit && page_started) begin
        page_started = 1'b0;
        vpos = TopLine;
        pages++;
        add(KIND_PAGE, 8'h00, 1'b0, 1'b0, 1'b0, 0, 0, 1'b1);
      end
    endfunction

    // One dot per set pin, lowest pin first, then the column advance.
    function void fire_column(logic [7:0] c0, logic [7:0] c1);
      logic [8:0]  pins;
      int          n;
      int unsigned y;
      pins = {c0[0], c1};
      n = 0;
      for (int p = 0; p < 9; p++) begin
        if (pins[p]) begin
          y = vpos + p * pitch;
          if (y > YMax) y = YMax;
          page_started = 1'b1;
          add(KIND_DOT, 8'h00, 1'b0, 1'b0, 1'b0, head, y, 1'b0);
          n++;
        end
      end
      if (n > 0) awaited_q[awaited_q.size() - 1].last = 1'b1;
      dots += n;
      move_head((longint'(c0[3:1]) + ColBase) * step_now());
    endfunction

    function void run_command(logic [7:0] c0, logic [7:0] c1, bit cmd_port);
      longint h;
      case (mode)
        MODE_LINEFEED: begin
          if (c0 == CmdStop) begin
            mode = MODE_NORMAL;
          end else if (c0 == CmdLfFeed) begin
            feed(FullFeed);
            check_page_end();
          end
        end
        MODE_PRINTING: begin
          if (c0 >= HeadMoveLo && c0 < CmdStop) begin
            h = longint'(c0 - HeadMoveLo) * FullFeed + (c1 != 0 ? c1 : FullFeed);
            move_head(h * step_now());
          end else if (c0[7:6] == 2'b00) begin
            fire_column(c0, c1);
          end else if (c0 == CmdStop && c1 == 0) begin
            mode = MODE_NORMAL;
            move_head(StopTrim * step_now());
          end
        end
        default: begin
          if (c0 == CmdFeed) begin
            feed(c1);
          end else if (c0[7:2] == CmdStartBase[7:2]) begin
            h = (c1 != 0) ? c1 : FullFeed;
            mode = MODE_PRINTING;
            dir_left = !c0[0];
            slow = c0[1];
            move_head((h - StartTrim) * step_now());
          end else if (c0 == CmdLfMode) begin
            feed(c1);
            mode = MODE_LINEFEED;
            check_page_end();
          end else if (c0 == CmdReset && cmd_port && c1 == 0) begin
            head = 0;
            slow = 1'b0;
            dir_left = 1'b0;
            mode = MODE_NORMAL;
          end
        end
      endcase
    endfunction

    // Called for every accepted input beat.
    function void note_beat(bit op, bit port, logic [7:0] data);
      beats++;
      if (op == OpRead) begin
        reads++;
        if (!enabled) add(KIND_READ, 8'h00, 1'b1, 1'b0, 1'b0, 0, 0, 1'b1);
        else if (port == PortCmd) add(KIND_READ, IdByte, 1'b0, 1'b0, 1'b0, 0, 0, 1'b1);
        else add(KIND_READ, 8'h00, 1'b0, bail_in, head > 0, 0, 0, 1'b1);
      end else if (!have_first) begin
        have_first = 1'b1;
        first_byte = data;
      end else begin
        have_first = 1'b0;
        run_command(first_byte, data, port == PortCmd);
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Called for every accepted result beat.
    function void check_result(res_t got);
      res_t want;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with none expected, actual kind %0d dot_x 0x%0h dot_y %0d",
                   $time, got.kind, got.dot_x, got.dot_y);
        return;
      end
      want = awaited_q.pop_front();
      compare("kind", want.kind, got.kind);
      compare("id_byte", want.id_byte, got.id_byte);
      compare("no_printer", want.no_printer, got.no_printer);
      compare("bail_flag", want.bail_flag, got.bail_flag);
      compare("head_away", want.head_away, got.head_away);
      compare("dot_x", want.dot_x, got.dot_x);
      compare("dot_y", want.dot_y, got.dot_y);
      compare("last", want.last, got.last);
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [55:0]            m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  // Set by the stimulus; the receiver counts a hold-off down on its own.
  bit calm = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  print_head_scoreboard sb = new();

  dot_matrix_print_head_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Result side: check each accepted beat, then pick the next ready value.
  always @(posedge clk_i) begin : result_side
    res_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind = kind_e'(m_axis_tuser);
      got.id_byte = m_axis_tdata[7:0];
      got.no_printer = m_axis_tdata[8];
      got.bail_flag = m_axis_tdata[9];
      got.head_away = m_axis_tdata[10];
      got.dot_x = m_axis_tdata[33:11];
      got.dot_y = m_axis_tdata[49:34];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // One input beat, with random idle cycles ahead of it.
  task automatic send_beat(bit op, bit port, logic [7:0] data);
    if (!calm) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {port, op};
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(op, port, data);
  endtask

  // Two writes; a read now and then falls between the bytes.
  task automatic send_cmd(logic [7:0] c0, logic [7:0] c1, bit port1);
    send_beat(OpWrite, $urandom_range(0, 1), c0);
    if ($urandom_range(0, 99) < 8) send_beat(OpRead, $urandom_range(0, 1), $urandom_range(0, 255));
    send_beat(OpWrite, port1, c1);
  endtask

  // Completes a dangling first byte so the next command pairs up.
  task automatic realign();
    if (sb.have_first) send_beat(OpWrite, $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  task automatic to_normal_mode();
    realign();
    if (sb.mode != MODE_NORMAL) send_cmd(CmdStop, 8'h00, $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(bit en, bit bail, logic [3:0] fast, logic [3:0] slw,
                                logic [4:0] pin_gap, logic [12:0] lim);
    cfg_write(CfgEnable, en);
    cfg_write(CfgBail, bail);
    cfg_write(CfgFastStep, fast);
    cfg_write(CfgSlowStep, slw);
    cfg_write(CfgPitch, pin_gap);
    cfg_write(CfgLimit, lim);
    cfg_valid_i <= 1'b0;
  endtask

  // A print pass with random columns, moves and reads.
  task automatic print_pass(int cols);
    int k;
    send_cmd({CmdStartBase[7:2], 2'($urandom_range(0, 3))}, $urandom_range(0, 255),
             $urandom_range(0, 1));
    repeat (cols) begin
      k = $urandom_range(0, 99);
      if (k < 70)
        send_cmd({2'b00, 6'($urandom_range(0, 63))}, $urandom_range(0, 255), $urandom_range(0, 1));
      else if (k < 85)
        send_cmd(HeadMoveLo + 8'($urandom_range(0, 63)), $urandom_range(0, 255),
                 $urandom_range(0, 1));
      else
        send_beat(OpRead, $urandom_range(0, 1), $urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 85) send_cmd(CmdStop, 8'h00, $urandom_range(0, 1));
    else send_cmd(CmdStop, $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // Mostly well-formed command sequences, some noise and broken pairs.
  task automatic random_run(int count);
    int stop_at;
    int pick;
    stop_at = sb.beats + count;
    while (sb.beats < stop_at) begin
      if ($urandom_range(0, 99) < 85) realign();
      if (sb.mode != MODE_NORMAL && $urandom_range(0, 99) < 85)
        send_cmd(CmdStop, 8'h00, $urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        print_pass($urandom_range(1, 8));
      end else if (pick < 50) begin
        send_cmd(CmdLfMode, $urandom_range(0, 255), $urandom_range(0, 1));
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 99) < 85)
            send_cmd(CmdLfFeed, $urandom_range(0, 255), $urandom_range(0, 1));
          else
            send_cmd($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        end
        send_cmd(CmdStop, $urandom_range(0, 255), $urandom_range(0, 1));
      end else if (pick < 62) begin
        send_cmd(CmdFeed, $urandom_range(0, 255), $urandom_range(0, 1));
      end else if (pick < 75) begin
        send_beat(OpRead, $urandom_range(0, 1), $urandom_range(0, 255));
      end else if (pick < 82) begin
        send_cmd(CmdReset, ($urandom_range(0, 99) < 90) ? 8'h00 : 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 99) < 70) ? PortCmd : PortData);
      end else begin
        send_beat(OpWrite, $urandom_range(0, 1), $urandom_range(0, 255));
      end
    end
  endtask

  // Paper fed to its limit with no page started, then the fixed cases.
  task automatic directed_checks();
    send_cmd(CmdLfMode, 8'h00, PortData);
    repeat (256) send_cmd(CmdLfFeed, $urandom_range(0, 255), $urandom_range(0, 1));
    send_cmd(CmdStop, $urandom_range(0, 255), $urandom_range(0, 1));

    send_beat(OpRead, PortCmd, 8'h00);
    send_beat(OpRead, PortData, 8'hFF);
    // Full-width pass, fast and to the right; pins land past the paper end.
    send_cmd({CmdStartBase[7:2], 2'b01}, 8'h00, PortCmd);
    send_cmd(8'h01, 8'hFF, PortData);
    send_cmd(8'h3F, 8'h00, PortCmd);
    send_cmd(HeadMoveLo + 8'h3F, 8'h00, PortData);
    send_beat(OpRead, PortData, 8'h00);
    send_cmd(CmdStop, 8'h00, PortCmd);
    send_cmd(8'hFF, 8'hFF, PortData);
    // Line feed mode with a started page past the limit ejects it.
    send_cmd(CmdLfMode, 8'hFF, PortCmd);
    send_cmd(CmdLfFeed, 8'h00, PortData);
    send_cmd(CmdStop, 8'h00, PortCmd);
    // The reset command only counts on the command port.
    send_cmd(CmdReset, 8'h00, PortData);
    send_cmd(CmdReset, 8'h00, PortCmd);
    send_cmd(CmdFeed, 8'hFF, PortCmd);
    // Slow leftward pass shorter than the start trim.
    send_cmd({CmdStartBase[7:2], 2'b10}, 8'h01, PortData);
    send_cmd(CmdStop, 8'h00, PortCmd);
  endtask

  // Drives the head into both ends of its range and fires pins there.
  task automatic head_sweep();
    to_normal_mode();
    send_cmd({CmdStartBase[7:2], 2'b01}, 8'h00, PortCmd);
    repeat (20) send_cmd(HeadMoveLo + 8'h3F, 8'h00, $urandom_range(0, 1));
    send_cmd(8'h01, 8'hFF, PortData);
    send_beat(OpRead, PortData, 8'h00);
    send_cmd(CmdStop, 8'h00, PortCmd);
    send_cmd({CmdStartBase[7:2], 2'b00}, 8'h00, PortCmd);
    repeat (40) send_cmd(HeadMoveLo + 8'h3F, 8'h00, $urandom_range(0, 1));
    send_cmd(8'h01, 8'hFF, PortData);
    send_cmd(CmdStop, 8'h00, PortCmd);
    send_beat(OpRead, PortData, 8'h00);
  endtask

  // Receiver holds off while full nine-pin columns keep coming.
  task automatic backlog_burst();
    to_normal_mode();
    hold_req <= hold_req + 1;
    send_cmd({CmdStartBase[7:2], 2'b11}, $urandom_range(0, 255), PortData);
    repeat (14) send_cmd(8'h01, 8'hFF, $urandom_range(0, 1));
    send_cmd(CmdStop, 8'h00, PortCmd);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults.
    directed_checks();
    random_run(40);
    wait_idle();

    // Widest fast step and pitch, narrowest slow step, highest page limit.
    apply_settings(1'b1, 1'b0, 4'd15, 4'd1, 5'd31, 13'd8191);
    head_sweep();
    random_run(45);
    wait_idle();

    // Printer off, narrowest fast step and pitch, widest slow step, lowest page limit.
    apply_settings(1'b0, 1'b1, 4'd1, 4'd15, 5'd1, 13'd1);
    backlog_burst();
    random_run(45);
    wait_idle();

    // Zero steps and pitch.
    apply_settings(1'b1, 1'b1, 4'd0, 4'd0, 5'd0, 13'd700);
    random_run(40);
    wait_idle();

    // Random settings with both streams running flat out.
    apply_settings($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 15),
                   $urandom_range(1, 15), $urandom_range(1, 31), $urandom_range(300, 3000));
    calm <= 1'b1;
    random_run(40);
    wait_idle();

    $display("Run covered %0d port accesses (%0d reads), %0d dots and %0d page ejects",
             sb.beats, sb.reads, sb.dots, sb.pages);
    $display("over five register settings, with head and paper saturation and a full backlog.");
    if (sb.errors == 0) begin
      $display("dot_matrix_print_head_controller_test: clean");
    end else begin
      $display("dot_matrix_print_head_controller_test: errors");
    end
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("Timed out with %0d results still expected.", sb.pending());
    $display("dot_matrix_print_head_controller_test: errors");
    $finish;
  end

endmodule
